// ===== hw/rtl/sfto_pkg.sv =====
// Shared types, constants, sine table and microprogram for the fade and tone overlay core.
package sfto_pkg;

  // Configuration port geometry.
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PEAK       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DECAY      = 3'd4;

  localparam logic [30:0] RST_PHASE_STEP = 31'd42852281;
  localparam logic [14:0] RST_PEAK       = 15'd3932;
  localparam logic [15:0] RST_LENGTH     = 16'd17640;
  localparam logic [15:0] RST_ATTACK     = 16'd2205;
  localparam logic [15:0] RST_DECAY      = 16'd2205;

  // Sample limits.
  localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;
  localparam logic [14:0] SINE_ONE   = 15'd32767;

  // Quarter-wave sine table.
  localparam int SINE_DEPTH = 256;
  localparam int TAB_BITS   = $clog2(SINE_DEPTH);

  // Envelope divider: dividend is tone_peak times a 16-bit frame count.
  localparam int DIV_W     = 31;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] Q30_PI  = 64'd3373259426;
  localparam int TAYLOR_TERMS = 7;
  localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

  typedef logic [14:0] sine_tab_t [SINE_DEPTH];

  // Builds round(32767 * sin(pi/2 * i / D)) with a Q30 Taylor series.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic        [63:0] x;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [63:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x    = (Q30_PI * 64'(i)) >> (TAB_BITS + 1);
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = ((64'(sum) * 64'd32767) + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[i] = 15'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  typedef struct packed {
    logic [30:0] phase_step;
    logic [14:0] peak;
    logic [15:0] length;
    logic [15:0] attack;
    logic [15:0] decay;
  } cfg_t;

  // Datapath operations, one per microprogram step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_L,
    OP_MUL_R,
    OP_FADE_R,
    OP_SINE,
    OP_MUL_ATT,
    OP_DIV_ATT,
    OP_MUL_DEC,
    OP_DIV_DEC,
    OP_ENV_DIV,
    OP_MUL_TONE,
    OP_TONE,
    OP_MIX,
    OP_EMIT
  } op_t;

  // Jump conditions; when false the step counter advances by one.
  typedef enum logic [3:0] {
    COND_NEXT,
    COND_JUMP,
    COND_NO_INPUT,
    COND_PASS,
    COND_UNITY,
    COND_NO_TONE,
    COND_NOT_ATT,
    COND_NOT_DEC,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  localparam int PC_W     = 4;
  localparam int PROG_LEN = 2 ** PC_W;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_TONE  = 4'd5;
  localparam pc_t PC_DEC   = 4'd8;
  localparam pc_t PC_ENV   = 4'd10;
  localparam pc_t PC_SHAPE = 4'd11;
  localparam pc_t PC_EMIT  = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic pass;
    logic unity;
    logic no_tone;
    logic att;
    logic dec;
    logic div_busy;
    logic out_busy;
  } status_t;

  typedef ctrl_t ucode_t [PROG_LEN];

  localparam ucode_t UCODE = '{
    '{OP_LOAD,     COND_NO_INPUT, PC_IDLE},   // 0: wait for an item
    '{OP_NOP,      COND_PASS,     PC_EMIT},   // 1: mute or bypass
    '{OP_MUL_L,    COND_UNITY,    PC_TONE},   // 2
    '{OP_MUL_R,    COND_NEXT,     PC_IDLE},   // 3
    '{OP_FADE_R,   COND_NEXT,     PC_IDLE},   // 4
    '{OP_SINE,     COND_NO_TONE,  PC_EMIT},   // 5: tone section
    '{OP_MUL_ATT,  COND_NOT_ATT,  PC_DEC},    // 6
    '{OP_DIV_ATT,  COND_JUMP,     PC_ENV},    // 7
    '{OP_MUL_DEC,  COND_NOT_DEC,  PC_SHAPE},  // 8
    '{OP_DIV_DEC,  COND_NEXT,     PC_IDLE},   // 9
    '{OP_ENV_DIV,  COND_DIV_BUSY, PC_ENV},    // 10
    '{OP_MUL_TONE, COND_NEXT,     PC_IDLE},   // 11
    '{OP_TONE,     COND_NEXT,     PC_IDLE},   // 12
    '{OP_MIX,      COND_JUMP,     PC_EMIT},   // 13
    '{OP_NOP,      COND_JUMP,     PC_IDLE},   // 14: unused
    '{OP_EMIT,     COND_OUT_BUSY, PC_EMIT}    // 15: wraps to 0
  };

endpackage

// ===== hw/rtl/sfto_div.sv =====
// Bit-serial restoring divider for the tone envelope.
module sfto_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sfto_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      busy,
  output logic [14:0]               quotient
);
  import sfto_pkg::*;

  logic [DIV_W-1:0]     dvd;
  logic [15:0]          den;
  logic [15:0]          rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [16:0]          trial;
  logic [16:0]          diff;
  logic                 ge;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign ge       = trial >= {1'b0, den};
  assign diff     = trial - {1'b0, den};
  assign quotient = dvd[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W - 1);
      dvd  <= dividend;
      den  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      // Quotient bits shift in where dividend bits leave.
      rem <= ge ? diff[15:0] : trial[15:0];
      dvd <= {dvd[DIV_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/sfto_seq.sv =====
// Microprogram sequencer: step counter, control store and jump logic.
module sfto_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sfto_pkg::status_t status,
  output sfto_pkg::ctrl_t   ctrl
);
  import sfto_pkg::*;

  pc_t  pc;
  pc_t  pc_next;
  logic take;

  assign ctrl = UCODE[pc];

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:     take = 1'b0;
      COND_JUMP:     take = 1'b1;
      COND_NO_INPUT: take = !in_valid;
      COND_PASS:     take = status.pass;
      COND_UNITY:    take = status.unity;
      COND_NO_TONE:  take = status.no_tone;
      COND_NOT_ATT:  take = !status.att;
      COND_NOT_DEC:  take = !status.dec;
      COND_DIV_BUSY: take = status.div_busy;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hw/rtl/sfto_dp.sv =====
// Datapath: working samples, shared multiplier, tone state, envelope and output register.
module sfto_dp #(
  parameter int PHASE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  sfto_pkg::ctrl_t   ctrl,
  input  sfto_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  logic [15:0]       left_in,
  input  logic [15:0]       right_in,
  input  logic [15:0]       fade_gain,
  input  logic              mute,
  input  logic              bypass,
  input  logic              start_tone,
  output sfto_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       left_out,
  output logic [15:0]       right_out,
  output logic              tone_active
);
  import sfto_pkg::*;

  // Working item.
  logic [15:0] l;
  logic [15:0] r;
  logic [15:0] gain;
  logic        mute_r;
  logic        bypass_r;
  logic        mixed;

  // Tone state.
  logic [PHASE_BITS-1:0] phase;
  logic [15:0]           remaining;

  logic [31:0] prod;
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [14:0] env;
  logic [14:0] smag;
  logic        sneg;
  logic [15:0] tone;

  logic [15:0] l_mag;
  logic [15:0] r_mag;
  logic [15:0] faded;
  logic [15:0] played;

  logic [1:0]          quad;
  logic [TAB_BITS-1:0] k;
  logic [TAB_BITS-1:0] k_mirror;
  logic [14:0]         sine_mag;

  logic [14:0] q0;
  logic [16:0] q_rem;
  logic [14:0] tone_q;

  logic [16:0] l_sum;
  logic [16:0] r_sum;

  logic        div_start;
  logic [15:0] div_den;
  logic        div_busy;
  logic [14:0] div_quo;

  logic accept;
  logic emit;

  assign accept = (ctrl.op == OP_LOAD) && in_valid;
  assign emit   = (ctrl.op == OP_EMIT) && !status.out_busy;

  assign l_mag  = l[15] ? 16'(-l) : l;
  assign r_mag  = r[15] ? 16'(-r) : r;
  assign played = (cfg.length >= remaining) ? cfg.length - remaining : '0;

  // Fade magnitude is below 2^15 since the gain is below unity here.
  assign faded = {1'b0, prod[29:15]};

  assign status.pass     = mute_r || bypass_r;
  assign status.unity    = gain[15];
  assign status.no_tone  = (remaining == '0);
  assign status.att      = played < cfg.attack;
  assign status.dec      = remaining < cfg.decay;
  assign status.div_busy = div_busy;
  assign status.out_busy = out_valid && out_stall;

  // Quarter-wave lookup: odd quadrants read the table mirrored.
  assign quad     = phase[PHASE_BITS-1 -: 2];
  assign k        = phase[PHASE_BITS-3 -: TAB_BITS];
  assign k_mirror = TAB_BITS'(0) - k;
  assign sine_mag = !quad[0] ? SINE_TAB[k] : (k == '0) ? SINE_ONE : SINE_TAB[k_mirror];

  // Division of the tone product by 32767: p = 32768*q0 + low, so p = 32767*q0 + (low + q0),
  // and that remainder stays below twice 32767 for every product of two 15-bit values.
  assign q0     = prod[29:15];
  assign q_rem  = {2'b00, prod[14:0]} + {2'b00, q0};
  assign tone_q = q0 + 15'(q_rem >= {2'b00, SINE_ONE});

  assign l_sum = {l[15], l} + {tone[15], tone};
  assign r_sum = {r[15], r} + {tone[15], tone};

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_den   = cfg.attack;
    unique case (ctrl.op)
      OP_MUL_L: begin
        mul_a = l_mag;
        mul_b = gain;
      end
      OP_MUL_R: begin
        mul_a = r_mag;
        mul_b = gain;
      end
      OP_MUL_ATT: begin
        mul_a = {1'b0, cfg.peak};
        mul_b = played;
      end
      OP_MUL_DEC: begin
        mul_a = {1'b0, cfg.peak};
        mul_b = remaining;
      end
      OP_MUL_TONE: begin
        mul_a = {1'b0, smag};
        mul_b = {1'b0, env};
      end
      OP_DIV_ATT: begin
        div_start = 1'b1;
        div_den   = cfg.attack;
      end
      OP_DIV_DEC: begin
        div_start = 1'b1;
        div_den   = cfg.decay;
      end
      default: begin
      end
    endcase
  end

  sfto_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DIV_W-1:0]),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && start_tone) begin
        phase     <= '0;
        remaining <= cfg.length;
      end
      if (ctrl.op == OP_MIX) begin
        phase     <= phase + PHASE_BITS'(cfg.phase_step);
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_MUL_L || ctrl.op == OP_MUL_R || ctrl.op == OP_MUL_ATT ||
        ctrl.op == OP_MUL_DEC || ctrl.op == OP_MUL_TONE) begin
      prod <= {16'b0, mul_a} * {16'b0, mul_b};
    end
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          l        <= mute ? '0 : left_in;
          r        <= mute ? '0 : right_in;
          gain     <= fade_gain;
          mute_r   <= mute;
          bypass_r <= bypass;
          mixed    <= 1'b0;
        end
      end
      OP_MUL_R: begin
        l <= l[15] ? 16'(-faded) : faded;
      end
      OP_FADE_R: begin
        r <= r[15] ? 16'(-faded) : faded;
      end
      OP_SINE: begin
        smag <= sine_mag;
        sneg <= quad[1];
        env  <= cfg.peak;
      end
      OP_ENV_DIV: begin
        env <= div_quo;
      end
      OP_TONE: begin
        tone <= sneg ? 16'(-{1'b0, tone_q}) : {1'b0, tone_q};
      end
      OP_MIX: begin
        l     <= (l_sum[16] != l_sum[15]) ? (l_sum[16] ? SAMPLE_MIN : SAMPLE_MAX) : l_sum[15:0];
        r     <= (r_sum[16] != r_sum[15]) ? (r_sum[16] ? SAMPLE_MIN : SAMPLE_MAX) : r_sum[15:0];
        mixed <= 1'b1;
      end
      OP_EMIT: begin
        if (emit) begin
          left_out    <= l;
          right_out   <= r;
          tone_active <= mixed;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/stereo_fade_and_tone_overlay_core.sv =====
// Top level of the stereo fade and tone overlay core: configuration registers and block wiring.
//
// Each stereo frame is processed by a 16-step microprogram that drives one shared 16x16
// multiplier and a bit-serial divider. A muted or bypassed frame goes straight to the output
// register. A frame with no tone skips the tone section, and a frame at unity gain skips the
// fade multiplies. During the attack or decay ramp the envelope is divided on the bit-serial
// divider, and the sequencer waits for its quotient before shaping the tone. A new frame is
// accepted once the previous result sits in the output register, so a result waiting on a stalled
// output does not hold up the next frame's processing.
module stereo_fade_and_tone_overlay_core #(
  parameter int PHASE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfto_pkg::PADDR_W-1:0] paddr,
  input  logic [sfto_pkg::PDATA_W-1:0] pwdata,
  output logic [sfto_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [15:0]                  left_in,
  input  logic [15:0]                  right_in,
  input  logic [15:0]                  fade_gain,
  input  logic                         mute,
  input  logic                         bypass,
  input  logic                         start_tone,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  left_out,
  output logic [15:0]                  right_out,
  output logic                         tone_active
);
  import sfto_pkg::*;

  cfg_t                 cfg;
  ctrl_t                ctrl;
  status_t              status;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = (ctrl.op != OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= RST_PHASE_STEP;
      cfg.peak       <= RST_PEAK;
      cfg.length     <= RST_LENGTH;
      cfg.attack     <= RST_ATTACK;
      cfg.decay      <= RST_DECAY;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PHASE_STEP: cfg.phase_step <= pwdata[30:0];
        REG_PEAK:       cfg.peak       <= pwdata[14:0];
        REG_LENGTH:     cfg.length     <= pwdata[15:0];
        REG_ATTACK:     cfg.attack     <= pwdata[15:0];
        REG_DECAY:      cfg.decay      <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP: prdata = {1'b0, cfg.phase_step};
      REG_PEAK:       prdata = {17'b0, cfg.peak};
      REG_LENGTH:     prdata = {16'b0, cfg.length};
      REG_ATTACK:     prdata = {16'b0, cfg.attack};
      REG_DECAY:      prdata = {16'b0, cfg.decay};
      default:        prdata = '0;
    endcase
  end

  sfto_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  sfto_dp #(
    .PHASE_BITS (PHASE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .left_in     (left_in),
    .right_in    (right_in),
    .fade_gain   (fade_gain),
    .mute        (mute),
    .bypass      (bypass),
    .start_tone  (start_tone),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_out    (left_out),
    .right_out   (right_out),
    .tone_active (tone_active)
  );

endmodule

// ===== tb/stereo_fade_and_tone_overlay_core_test.sv =====
// Self-checking testbench for the stereo fade and tone overlay core.
`timescale 1ns / 100ps

module stereo_fade_and_tone_overlay_core_test;
  import sfto_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] gain;
    logic        mute;
    logic        bypass;
    logic        start;
  } frame_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        active;
  } mix_result_t;

  localparam u64_t ONE_Q30       = 64'd1073741824;
  localparam u64_t PI_Q30        = 64'd3373259426;
  localparam int   SETTLE_CYCLES = 60;
  localparam int   CYCLE_LIMIT   = 1000000;
  localparam int   FRAMES_PER_PHASE = 125;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [15:0]         left_in     = '0;
  logic [15:0]         right_in    = '0;
  logic [15:0]         fade_gain   = '0;
  logic                mute        = 1'b0;
  logic                bypass      = 1'b0;
  logic                start_tone  = 1'b0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [15:0]         left_out;
  logic [15:0]         right_out;
  logic                tone_active;

  // Shadow of the configuration registers and the tone state.
  logic [30:0] cfg_step   = RST_PHASE_STEP;
  logic [14:0] cfg_peak   = RST_PEAK;
  logic [15:0] cfg_length = RST_LENGTH;
  logic [15:0] cfg_attack = RST_ATTACK;
  logic [15:0] cfg_decay  = RST_DECAY;
  logic [15:0] tone_left  = '0;
  logic [31:0] tone_phase = '0;
  int          sine_q15 [256];

  mix_result_t expected_frames [$];
  mix_result_t want;
  int          errors     = 0;
  int          cycles     = 0;
  int          stall_hold = 0;
  bit          idle_on    = 1'b1;

  stereo_fade_and_tone_overlay_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_in    (left_in),
    .right_in   (right_in),
    .fade_gain  (fade_gain),
    .mute       (mute),
    .bypass     (bypass),
    .start_tone (start_tone),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out),
    .tone_active(tone_active)
  );

  always #5 clk = ~clk;

  // Quarter-wave table, round(32767 * sin(pi/2 * i / 256)) from a Q30 Taylor series.
  initial begin : quarter_sine
    u64_t   x;
    u64_t   term;
    longint sum;
    longint v;
    for (int i = 0; i < 256; i++) begin
      x    = (PI_Q30 * u64_t'(i)) / 64'd512;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / (u64_t'(2 * n) * u64_t'(2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = longint'((u64_t'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30);
      if (v > 32767) begin
        v = 32767;
      end
      sine_q15[i] = int'(v);
    end
  end

  function automatic int pick_idle();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Q1.15 scaling with the product truncated toward zero.
  function automatic int scale_q15(int x, int unsigned g);
    u64_t mag;
    int   r;
    mag = (x < 0) ? u64_t'(-x) : u64_t'(x);
    r   = int'((mag * u64_t'(g)) >> 15);
    return (x < 0) ? -r : r;
  endfunction

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return SAMPLE_MAX;
    if (v < -32768) return SAMPLE_MIN;
    return v[15:0];
  endfunction

  // Expected output of one frame; advances the tone state as the block does.
  function automatic mix_result_t mix_frame(frame_t f);
    mix_result_t o;
    int          l;
    int          r;
    int          mag;
    int          tone;
    u64_t        rem;
    u64_t        played;
    u64_t        env;
    logic [1:0]  quad;
    logic [7:0]  idx;
    l        = int'($signed(f.left));
    r        = int'($signed(f.right));
    o.active = 1'b0;
    if (f.start) begin
      tone_phase = '0;
      tone_left  = cfg_length;
    end
    if (f.mute) begin
      l = 0;
      r = 0;
    end else if (!f.bypass) begin
      if (f.gain < 16'd32768) begin
        l = scale_q15(l, 32'(f.gain));
        r = scale_q15(r, 32'(f.gain));
      end
      if (tone_left != 0) begin
        rem    = u64_t'(tone_left);
        played = (u64_t'(cfg_length) >= rem) ? u64_t'(cfg_length) - rem : 0;
        env    = u64_t'(cfg_peak);
        quad   = tone_phase[31:30];
        idx    = tone_phase[29:22];
        // Odd quadrants read the table mirrored; the top of the wave is not stored.
        if (quad[0]) begin
          mag = (idx == 0) ? 32767 : sine_q15[256 - idx];
        end else begin
          mag = sine_q15[idx];
        end
        if (played < u64_t'(cfg_attack)) begin
          env = (u64_t'(cfg_peak) * played) / u64_t'(cfg_attack);
        end else if (rem < u64_t'(cfg_decay)) begin
          env = (u64_t'(cfg_peak) * rem) / u64_t'(cfg_decay);
        end
        tone = int'((u64_t'(mag) * env) / 64'd32767);
        if (quad[1]) begin
          tone = -tone;
        end
        l          = int'($signed(clip16(l + tone)));
        r          = int'($signed(clip16(r + tone)));
        tone_phase = tone_phase + {1'b0, cfg_step};
        tone_left  = tone_left - 16'd1;
        o.active   = 1'b1;
      end
    end
    o.left  = l[15:0];
    o.right = r[15:0];
    return o;
  endfunction

  task automatic flag(string what, int want_v, int got_v);
    errors++;
    if (errors <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    end
  endtask

  task automatic send_frame(logic [15:0] l, logic [15:0] r, logic [15:0] g,
                            logic m, logic b, logic s);
    frame_t f;
    int     gap;
    f   = '{left: l, right: r, gain: g, mute: m, bypass: b, start: s};
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    left_in    <= l;
    right_in   <= r;
    fade_gain  <= g;
    mute       <= m;
    bypass     <= b;
    start_tone <= s;
    do @(posedge clk); while (in_stall);
    expected_frames.insert(expected_frames.size(), mix_frame(f));
  endtask

  // Returns once every expected frame has come out and the core has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    logic [31:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PHASE_STEP: cfg_step   = value[30:0];
      REG_PEAK:       cfg_peak   = value[14:0];
      REG_LENGTH:     cfg_length = value[15:0];
      REG_ATTACK:     cfg_attack = value[15:0];
      REG_DECAY:      cfg_decay  = value[15:0];
      default: ;
    endcase
    case (idx)
      REG_PHASE_STEP: stored = {1'b0, cfg_step};
      REG_PEAK:       stored = {17'd0, cfg_peak};
      REG_LENGTH:     stored = {16'd0, cfg_length};
      REG_ATTACK:     stored = {16'd0, cfg_attack};
      default:        stored = {16'd0, cfg_decay};
    endcase
    // Read the register back.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      flag("register readback", int'(stored), int'(prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [31:0] step, logic [31:0] peak, logic [31:0] length,
                           logic [31:0] attack, logic [31:0] decay);
    wait_idle();
    set_reg(REG_PHASE_STEP, step);
    set_reg(REG_PEAK, peak);
    set_reg(REG_LENGTH, length);
    set_reg(REG_ATTACK, attack);
    set_reg(REG_DECAY, decay);
  endtask

  task automatic test_mute_bypass();
    send_frame(16'h7FFF, 16'h8000, 16'd12345, 1'b1, 1'b0, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 16'd0, 1'b1, 1'b1, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 16'd0, 1'b0, 1'b1, 1'b0);
    send_frame(16'h0001, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_fade_gain();
    send_frame(16'h7FFF, 16'h8000, 16'd0, 1'b0, 1'b0, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 16'd1, 1'b0, 1'b0, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 16'd32767, 1'b0, 1'b0, 1'b0);
    send_frame(16'hFFFF, 16'd12345, 16'd32768, 1'b0, 1'b0, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
  endtask

  // Short loud tone that walks all four quadrants against full-scale samples.
  task automatic test_tone_overlay();
    configure(32'h3000_0000, 32'd32767, 32'd6, 32'd2, 32'd2);
    send_frame(16'd500, 16'd500, 16'd32768, 1'b1, 1'b0, 1'b1);
    send_frame(16'd100, 16'hFF9C, 16'd32768, 1'b0, 1'b1, 1'b0);
    send_frame(16'd100, 16'hFF9C, 16'd32768, 1'b0, 1'b1, 1'b1);
    for (int n = 0; n < 6; n++) begin
      if (n % 2 == 0) begin
        send_frame(16'h7FFF, 16'h8000, 16'd32768, 1'b0, 1'b0, 1'b0);
      end else begin
        send_frame(16'h8000, 16'h7FFF, 16'd32768, 1'b0, 1'b0, 1'b0);
      end
    end
    send_frame(16'd7, 16'd7, 16'd32768, 1'b0, 1'b0, 1'b0);
  endtask

  // Zero ramps, a length shortened under a running tone, and a zero length.
  task automatic test_length_edges();
    configure(32'h0123_4567, 32'd20000, 32'd40, 32'd0, 32'd0);
    send_frame(16'd0, 16'd0, 16'd16384, 1'b0, 1'b0, 1'b1);
    send_frame(16'd1000, 16'hFC18, 16'd16384, 1'b0, 1'b0, 1'b0);
    send_frame(16'd1000, 16'hFC18, 16'd16384, 1'b0, 1'b0, 1'b0);
    configure(32'h0123_4567, 32'd20000, 32'd3, 32'd5, 32'd5);
    send_frame(16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0);
    send_frame(16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0);
    configure(32'h0123_4567, 32'd20000, 32'd0, 32'd0, 32'd0);
    send_frame(16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b1);
    send_frame(16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int unsigned len;
    int          since_start;
    logic [15:0] g;
    logic        s;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          len = $urandom_range(1, 60);
          configure($urandom(), $urandom_range(0, 32767), len,
                    $urandom_range(1, len), $urandom_range(1, len));
        end
        1: configure(32'h7FFF_FFFF, 32'd32767, 32'd65535, 32'd65535, 32'd65535);
        2: configure(32'd0, 32'd0, 32'd1, 32'd1, 32'd1);
        3: configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        4: begin
          len = $urandom_range(30, 100);
          configure($urandom(), 32'd32767, len, $urandom_range(1, 10), $urandom_range(1, 10));
        end
        default: configure(32'(RST_PHASE_STEP), 32'(RST_PEAK), 32'(RST_LENGTH),
                           32'(RST_ATTACK), 32'(RST_DECAY));
      endcase
      idle_on     = (ph != 2 && ph != 4);
      since_start = 0;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: g = 16'd32768;
          5, 6:          g = 16'($urandom_range(32768, 65535));
          7:             g = 16'd0;
          default:       g = 16'($urandom_range(0, 32767));
        endcase
        // Restart mostly after the previous tone has run out, so whole envelopes play.
        s = (n == 0) || (since_start > int'(cfg_length) && $urandom_range(0, 3) == 0) ||
            ($urandom_range(0, 99) == 0);
        since_start = s ? 0 : since_start + 1;
        send_frame(pick_sample(), pick_sample(), g, $urandom_range(0, 24) == 0,
                   $urandom_range(0, 24) == 0, s);
      end
    end
  endtask

  // Result checker and output-side stall generator.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          flag("item with nothing expected", 0, 1);
        end else begin
          want = expected_frames.pop_front();
          if (left_out !== want.left) begin
            flag("left_out", int'($signed(want.left)), int'($signed(left_out)));
          end
          if (right_out !== want.right) begin
            flag("right_out", int'($signed(want.right)), int'($signed(right_out)));
          end
          if (tone_active !== want.active) begin
            flag("tone_active", int'(want.active), int'(tone_active));
          end
        end
      end
      if (stall_hold > 0) begin
        out_stall  <= 1'b1;
        stall_hold <= stall_hold - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_hold <= pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("stereo_fade_and_tone_overlay_core_test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_mute_bypass();
    test_fade_gain();
    test_tone_overlay();
    test_length_edges();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("stereo_fade_and_tone_overlay_core_test passed");
    end else begin
      $display("stereo_fade_and_tone_overlay_core_test failed");
    end
    $finish;
  end

endmodule
